FILE: design/hvd_pkg.sv
// hvd_pkg: fixed-point constants, cell word types and the arctangent table
// for the haversine distance pipeline. No dependencies.
package hvd_pkg;

    localparam int ANG_W      = 34;
    localparam int SQ_W       = 64;
    localparam int MAG_W      = 33;
    localparam int SQRT_STEPS = 32;

    localparam logic [SQ_W-1:0]  ONE_Q30       = 64'd1073741824;
    localparam logic [MAG_W-1:0] PI_Q30        = 33'd3373259426;
    localparam logic [MAG_W-1:0] HALF_PI_Q30   = 33'd1686629713;
    localparam logic [30:0]      RAD_SCALE     = 31'd2012227627;
    localparam logic [ANG_W-1:0] CORDIC_GAIN   = 34'd652032874;

    typedef struct packed {
        logic signed [ANG_W-1:0] x;
        logic signed [ANG_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic [SQ_W-1:0] n;
        logic [SQ_W-1:0] r;
    } sqrt_t;

    function automatic logic signed [ANG_W-1:0] atan_q30(input int unsigned i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048576;
            11: v = 34'sd524288;
            12: v = 34'sd262144;
            13: v = 34'sd131072;
            14: v = 34'sd65536;
            15: v = 34'sd32768;
            16: v = 34'sd16384;
            17: v = 34'sd8192;
            18: v = 34'sd4096;
            19: v = 34'sd2048;
            20: v = 34'sd1024;
            21: v = 34'sd512;
            22: v = 34'sd256;
            23: v = 34'sd128;
            24: v = 34'sd64;
            25: v = 34'sd32;
            26: v = 34'sd16;
            27: v = 34'sd8;
            28: v = 34'sd4;
            29: v = 34'sd2;
            30: v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/hvd_rot_cell.sv
// hvd_rot_cell: one registered CORDIC rotation step (sine/cosine row).
// Depends on hvd_pkg.
module hvd_rot_cell #(
    parameter int IDX = 0
) (
    input  logic            clk,
    input  hvd_pkg::cordic_t d_in,
    output hvd_pkg::cordic_t d_out
);
    localparam int W = hvd_pkg::ANG_W;
    localparam logic signed [W-1:0] ANGLE = hvd_pkg::atan_q30(IDX);

    logic signed [W-1:0] xs, ys, zs, dx, dy;
    hvd_pkg::cordic_t q_reg, q_next;

    assign xs = d_in.x;
    assign ys = d_in.y;
    assign zs = d_in.z;
    assign dx = ys >>> IDX;
    assign dy = xs >>> IDX;

    always_comb
    begin
        if (!zs[W-1])
        begin
            q_next.x = xs - dx;
            q_next.y = ys + dy;
            q_next.z = zs - ANGLE;
        end
        else
        begin
            q_next.x = xs + dx;
            q_next.y = ys - dy;
            q_next.z = zs + ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign d_out = q_reg;
endmodule

FILE: design/hvd_vec_cell.sv
// hvd_vec_cell: one registered CORDIC vectoring step (arctangent row).
// Depends on hvd_pkg.
module hvd_vec_cell #(
    parameter int IDX = 0
) (
    input  logic            clk,
    input  hvd_pkg::cordic_t d_in,
    output hvd_pkg::cordic_t d_out
);
    localparam int W = hvd_pkg::ANG_W;
    localparam logic signed [W-1:0] ANGLE = hvd_pkg::atan_q30(IDX);

    logic signed [W-1:0] xs, ys, zs, dx, dy;
    hvd_pkg::cordic_t q_reg, q_next;

    assign xs = d_in.x;
    assign ys = d_in.y;
    assign zs = d_in.z;
    assign dx = ys >>> IDX;
    assign dy = xs >>> IDX;

    always_comb
    begin
        if (!ys[W-1])
        begin
            q_next.x = xs + dx;
            q_next.y = ys - dy;
            q_next.z = zs + ANGLE;
        end
        else
        begin
            q_next.x = xs - dx;
            q_next.y = ys + dy;
            q_next.z = zs - ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign d_out = q_reg;
endmodule

FILE: design/hvd_sqrt_cell.sv
// hvd_sqrt_cell: one registered digit step of the floor integer square root.
// Depends on hvd_pkg.
module hvd_sqrt_cell #(
    parameter int K = 0
) (
    input  logic          clk,
    input  hvd_pkg::sqrt_t d_in,
    output hvd_pkg::sqrt_t d_out
);
    localparam int W = hvd_pkg::SQ_W;
    localparam logic [W-1:0] BIT = 64'd1 << (62 - 2 * K);

    logic [W-1:0] trial;
    hvd_pkg::sqrt_t q_reg, q_next;

    assign trial = d_in.r + BIT;

    always_comb
    begin
        if (d_in.n >= trial)
        begin
            q_next.n = d_in.n - trial;
            q_next.r = (d_in.r >> 1) + BIT;
        end
        else
        begin
            q_next.n = d_in.n;
            q_next.r = d_in.r >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign d_out = q_reg;
endmodule

FILE: design/haversine_distance.sv
// haversine_distance: great-circle distance from a fix to a reference point.
// Depends on hvd_pkg, hvd_rot_cell, hvd_sqrt_cell, hvd_vec_cell.
//
// Usage:
//   Input channel: a fix word (fix_latitude, fix_longitude) is taken at each
//   rising edge with start high and busy low. busy is always low, so one
//   word can enter every clock cycle.
//   Result channel: distance_dm is valid for exactly one cycle while done is
//   high; the receiver cannot stall it and must take it in that cycle.
//   A fix taken while reference_enabled is 0 gives no result.
//   Config: APB port, reference_enabled at 0x0, reference_latitude at 0x4,
//   reference_longitude at 0x8; write only while no fix is in flight.
//   Pipeline: each fix passes through the front-end registers, the rotation
//   cell row, the product registers, the 32-cell square-root row, the
//   vectoring cell row and the scaling registers. Throughput: one word per cycle.
//   Reset: clears the configuration registers and the valid line, dropping every in-flight word.
module haversine_distance #(
    parameter int TRIG_ITERATIONS = 24,
    parameter int EARTH_RADIUS_M  = 6371009
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [30:0] fix_latitude,
    input  logic [31:0] fix_longitude,
    output logic        done,
    output logic [27:0] distance_dm,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int N   = TRIG_ITERATIONS;
    localparam int AW  = hvd_pkg::ANG_W;
    localparam int MW  = hvd_pkg::MAG_W;
    localparam int SW  = hvd_pkg::SQ_W;
    localparam int NSQ = hvd_pkg::SQRT_STEPS;
    localparam int LAT = 46 + 2 * N;
    localparam int RDM = 10 * EARTH_RADIUS_M;
    localparam int RW  = $clog2(RDM + 1);
    localparam logic [RW-1:0] RDM_C = RW'(RDM);
    localparam int PW  = RW + 32;

    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_LAT    = 2'd1;
    localparam logic [1:0] REG_LON    = 2'd2;

    // configuration
    logic               ref_en_reg;
    logic signed [30:0] ref_lat_reg;
    logic signed [31:0] ref_lon_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_en_reg  <= 1'b0;
            ref_lat_reg <= '0;
            ref_lon_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_ENABLE: ref_en_reg  <= pwdata[0];
                REG_LAT:    ref_lat_reg <= pwdata[30:0];
                REG_LON:    ref_lon_reg <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ENABLE: prdata = {31'd0, ref_en_reg};
            REG_LAT:    prdata = {ref_lat_reg[30], ref_lat_reg};
            REG_LON:    prdata = ref_lon_reg;
            default:    prdata = '0;
        endcase
    end

    function automatic logic [MW-1:0] abs34(input logic signed [33:0] v);
        logic signed [33:0] n;
        n = -v;
        return v[33] ? n[MW-1:0] : v[MW-1:0];
    endfunction

    // valid line
    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start & ~busy & ref_en_reg};
    end

    assign done = vld_reg[LAT-1];

    // front end: capture, magnitudes, radians, range reduction
    logic signed [30:0] lat_f_reg;
    logic signed [31:0] lon_f_reg;
    logic [MW-1:0]      mag_reg [4];
    logic [MW-1:0]      mag_next [4];
    logic [63:0]        prod_reg [4];
    logic [MW-1:0]      rad_reg [4];
    logic [MW-1:0]      rad_next [4];
    logic [MW-1:0]      red_reg [4];
    logic [MW-1:0]      red_next [4];
    logic [1:0]         neg_next;
    logic [1:0]         neg_pipe [N+1];

    hvd_pkg::cordic_t rot_d [4][N+1];
    hvd_pkg::cordic_t rot_next [4];

    always_comb
    begin
        logic [63:0] sum;
        mag_next[0] = abs34(34'(ref_lat_reg) - 34'(lat_f_reg));
        mag_next[1] = abs34(34'(ref_lon_reg) - 34'(lon_f_reg));
        mag_next[2] = abs34(34'(lat_f_reg));
        mag_next[3] = abs34(34'(ref_lat_reg));
        neg_next = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (k < 2)
            begin
                sum = prod_reg[k] + (64'd1 << 30);
                rad_next[k] = MW'(sum >> 31);
            end
            else
            begin
                sum = prod_reg[k] + (64'd1 << 29);
                rad_next[k] = MW'(sum >> 30);
            end
            red_next[k] = (rad_reg[k] >= hvd_pkg::PI_Q30) ?
                          rad_reg[k] - hvd_pkg::PI_Q30 : rad_reg[k];
            rot_next[k].x = hvd_pkg::CORDIC_GAIN;
            rot_next[k].y = '0;
            if (red_reg[k] > hvd_pkg::HALF_PI_Q30)
            begin
                rot_next[k].z = AW'(hvd_pkg::PI_Q30 - red_reg[k]);
                if (k >= 2)
                    neg_next[k-2] = 1'b1;
            end
            else
            begin
                rot_next[k].z = AW'(red_reg[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lat_f_reg <= fix_latitude;
        lon_f_reg <= fix_longitude;
        for (int k = 0; k < 4; k++)
        begin
            mag_reg[k]   <= mag_next[k];
            prod_reg[k]  <= 64'(mag_reg[k]) * 64'(hvd_pkg::RAD_SCALE);
            rad_reg[k]   <= rad_next[k];
            red_reg[k]   <= red_next[k];
            rot_d[k][0]  <= rot_next[k];
        end
        neg_pipe[0] <= neg_next;
        for (int i = 0; i < N; i++)
            neg_pipe[i+1] <= neg_pipe[i];
    end

    // rotation rows: half-angle sines and latitude cosines
    for (genvar k = 0; k < 4; k++)
    begin : g_rot_lane
        for (genvar i = 0; i < N; i++)
        begin : g_rot_cell
            hvd_rot_cell #(.IDX(i)) u_cell (
                .clk  (clk),
                .d_in (rot_d[k][i]),
                .d_out(rot_d[k][i+1])
            );
        end
    end

    // products and the haversine term a
    logic signed [AW-1:0] s1_reg, s2_reg, c1_reg, c2_reg;
    logic signed [AW-1:0] xc1, xc2;
    logic signed [35:0]   p1_reg, p2_reg, cc_reg, q1_reg, t_reg;
    logic signed [2*AW-1:0] sq1, sq2, sqc;
    logic signed [71:0]   pt;
    logic signed [36:0]   a_sum;
    logic [30:0]          a_reg, a_next;
    hvd_pkg::sqrt_t       sq_d [2][NSQ+1];

    assign xc1 = rot_d[2][N].x;
    assign xc2 = rot_d[3][N].x;
    assign sq1 = s1_reg * s1_reg;
    assign sq2 = s2_reg * s2_reg;
    assign sqc = c1_reg * c2_reg;
    assign pt  = p2_reg * cc_reg;
    assign a_sum = 37'(q1_reg) + 37'(t_reg);

    always_comb
    begin
        if (a_sum[36])
            a_next = '0;
        else if (a_sum > 37'(hvd_pkg::ONE_Q30))
            a_next = 31'(hvd_pkg::ONE_Q30);
        else
            a_next = a_sum[30:0];
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= rot_d[0][N].y;
        s2_reg <= rot_d[1][N].y;
        c1_reg <= neg_pipe[N][0] ? -xc1 : xc1;
        c2_reg <= neg_pipe[N][1] ? -xc2 : xc2;
        p1_reg <= 36'(sq1 >>> 30);
        p2_reg <= 36'(sq2 >>> 30);
        cc_reg <= 36'(sqc >>> 30);
        q1_reg <= p1_reg;
        t_reg  <= 36'(pt >>> 30);
        a_reg  <= a_next;
        sq_d[0][0].n <= SW'(a_reg) << 30;
        sq_d[0][0].r <= '0;
        sq_d[1][0].n <= (hvd_pkg::ONE_Q30 - SW'(a_reg)) << 30;
        sq_d[1][0].r <= '0;
    end

    // square-root rows: sqrt(a) and sqrt(1 - a)
    for (genvar k = 0; k < 2; k++)
    begin : g_sqrt_lane
        for (genvar i = 0; i < NSQ; i++)
        begin : g_sqrt_cell
            hvd_sqrt_cell #(.K(i)) u_cell (
                .clk  (clk),
                .d_in (sq_d[k][i]),
                .d_out(sq_d[k][i+1])
            );
        end
    end

    // vectoring row: half the central angle
    hvd_pkg::cordic_t vec_d [N+1];

    assign vec_d[0].x = AW'(sq_d[1][NSQ].r[31:0]);
    assign vec_d[0].y = AW'(sq_d[0][NSQ].r[31:0]);
    assign vec_d[0].z = '0;

    for (genvar i = 0; i < N; i++)
    begin : g_vec_cell
        hvd_vec_cell #(.IDX(i)) u_cell (
            .clk  (clk),
            .d_in (vec_d[i]),
            .d_out(vec_d[i+1])
        );
    end

    // scale to decimeters
    logic signed [AW:0] c2x;
    logic [31:0]        c_reg, c_next;
    logic [PW-1:0]      dp_reg;
    logic [PW-1:0]      dp_round;
    logic [27:0]        dist_reg;

    assign c2x = (AW+1)'(vec_d[N].z) <<< 1;
    assign c_next = c2x[AW] ? 32'd0 : c2x[31:0];
    assign dp_round = dp_reg + (PW'(1) << 29);

    always_ff @(posedge clk)
    begin
        c_reg    <= c_next;
        dp_reg   <= PW'(RDM_C) * PW'(c_reg);
        dist_reg <= dp_round[57:30];
    end

    assign distance_dm = dist_reg;
endmodule

FILE: tb/hvd_checker.sv
`timescale 1ns / 100ps
// hvd_checker: watches the fix, result and APB channels of haversine_distance,
// predicts each distance in fixed point and compares. Depends on the DUT ports.
module hvd_checker #(
    parameter int TRIG_ITERATIONS = 24,
    parameter int EARTH_RADIUS_M  = 6371009
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [30:0]       fix_latitude,
    input  logic [31:0]       fix_longitude,
    input  logic              done,
    input  logic [27:0]       distance_dm,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int unsigned       errors,
    output int unsigned       pending,
    output int unsigned       words_seen
);

    localparam logic [3:0] ADDR_ENABLE = 4'h0;
    localparam logic [3:0] ADDR_REF_LAT = 4'h4;
    localparam logic [3:0] ADDR_REF_LON = 4'h8;

    localparam longint ONE = 64'd1073741824;
    localparam longint PI = 64'd3373259426;
    localparam longint HALF_PI = 64'd1686629713;
    localparam longint unsigned RAD_K = 64'd2012227627;
    localparam longint GAIN = 64'd652032874;

    localparam longint ATAN_TBL [32] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
        128, 64, 32, 16, 8, 4, 2, 1, 0};

    logic   ref_on;
    longint ref_lat;
    longint ref_lon;
    logic [27:0] dist_q[$];

    function automatic int steps();
        return (TRIG_ITERATIONS > 32) ? 32 : TRIG_ITERATIONS;
    endfunction

    function automatic longint to_radians(longint unsigned mag, int extra);
        int s;
        s = 30 + extra;
        return longint'((mag * RAD_K + (64'd1 << (s - 1))) >> s);
    endfunction

    function automatic longint unsigned abs_of(longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    function automatic void rotate(input longint th, output longint cs,
                                   output longint sn);
        longint x, y, z, dx, dy;
        x = GAIN;
        y = 0;
        z = th;
        for (int i = 0; i < steps(); i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end
            else
            begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end
        end
        cs = x;
        sn = y;
    endfunction

    function automatic longint arc_angle(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < steps(); i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end
            else
            begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end
        end
        return z;
    endfunction

    function automatic longint unsigned root_of(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        for (int k = 0; k < 32; k++)
        begin
            b = 64'd1 << (62 - 2 * k);
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
        end
        return r;
    endfunction

    function automatic longint sine_of_half(longint h);
        longint c, s;
        h = h % PI;
        if (h > HALF_PI)
            h = PI - h;
        rotate(h, c, s);
        return s;
    endfunction

    function automatic longint cosine_of_lat(longint l);
        longint c, s;
        logic flip;
        flip = 1'b0;
        l = l % PI;
        if (l > HALF_PI)
        begin
            l = PI - l;
            flip = 1'b1;
        end
        rotate(l, c, s);
        return flip ? -c : c;
    endfunction

    function automatic logic [27:0] great_circle_dm(longint lat_f, longint lon_f);
        longint s1, s2, c1, c2, cc, a, c;
        longint unsigned u, v, d;
        s1 = sine_of_half(to_radians(abs_of(ref_lat - lat_f), 1));
        s2 = sine_of_half(to_radians(abs_of(ref_lon - lon_f), 1));
        c1 = cosine_of_lat(to_radians(abs_of(lat_f), 0));
        c2 = cosine_of_lat(to_radians(abs_of(ref_lat), 0));
        cc = (c1 * c2) >>> 30;
        a = ((s1 * s1) >>> 30) + ((((s2 * s2) >>> 30) * cc) >>> 30);
        if (a < 0)
            a = 0;
        if (a > ONE)
            a = ONE;
        u = root_of(longint'(a) << 30);
        v = root_of(longint'(ONE - a) << 30);
        c = 2 * arc_angle(u, v);
        if (c < 0)
            c = 0;
        d = (longint'(EARTH_RADIUS_M) * 10 * c + (64'd1 << 29)) >> 30;
        return d[27:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_on <= 1'b0;
            ref_lat <= 0;
            ref_lon <= 0;
            errors <= 0;
            words_seen <= 0;
            pending <= 0;
            dist_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    ADDR_ENABLE: ref_on <= pwdata[0];
                    ADDR_REF_LAT: ref_lat <= $signed(pwdata[30:0]);
                    ADDR_REF_LON: ref_lon <= $signed(pwdata[31:0]);
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                words_seen <= words_seen + 1;
                if (ref_on)
                    dist_q.push_back(great_circle_dm($signed(fix_latitude),
                                                     $signed(fix_longitude)));
            end
            if (done)
            begin
                if (dist_q.size() == 0)
                begin
                    $display("%0t: unexpected distance word, actual %0d", $time,
                             distance_dm);
                    errors <= errors + 1;
                end
                else
                begin
                    if (dist_q[0] !== distance_dm)
                    begin
                        $display("%0t: distance_dm mismatch, expected %0d actual %0d",
                                 $time, dist_q[0], distance_dm);
                        errors <= errors + 1;
                    end
                    void'(dist_q.pop_front());
                end
            end
            pending <= dist_q.size();
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// tb: stimulus and verdict for haversine_distance; fix words, partly under
// random gaps, and APB writes. Depends on haversine_distance and hvd_checker.
module tb;

    localparam logic [3:0] ADDR_ENABLE = 4'h0;
    localparam logic [3:0] ADDR_REF_LAT = 4'h4;
    localparam logic [3:0] ADDR_REF_LON = 4'h8;
    localparam int DRAIN_CYCLES = 130;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 7;
    localparam int WORDS_PER_PHASE = 190;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [30:0] fix_latitude;
    logic [31:0] fix_longitude;
    logic        done;
    logic [27:0] distance_dm;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int unsigned errors;
    int unsigned pending;
    int unsigned words_seen;
    int unsigned results;
    int unsigned cycles;
    logic        gaps_on;
    int          cur_lat;
    int          cur_lon;

    haversine_distance dut (.*);

    hvd_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .fix_latitude(fix_latitude), .fix_longitude(fix_longitude),
        .done(done), .distance_dm(distance_dm), .psel(psel),
        .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .errors(errors),
        .pending(pending), .words_seen(words_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (done)
            results <= results + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_reference(input logic on, input int lat, input int lon);
        reg_write(ADDR_REF_LAT, lat);
        reg_write(ADDR_REF_LON, lon);
        reg_write(ADDR_ENABLE, {31'd0, on});
        cur_lat = lat;
        cur_lon = lon;
    endtask

    task automatic send_fix(input logic [30:0] lat, input logic [31:0] lon);
        while (gaps_on && $urandom_range(99) < 37)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        fix_latitude <= lat;
        fix_longitude <= lon;
        do @(posedge clk); while (busy);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_fix();
        int lat, lon;
        case ($urandom_range(9))
            6, 7:
            begin
                lat = $urandom;
                lon = $urandom;
            end
            8, 9:
            begin
                lat = cur_lat + int'($urandom_range(2000000)) - 1000000;
                lon = cur_lon + int'($urandom_range(2000000)) - 1000000;
            end
            default:
            begin
                lat = int'($urandom_range(1800000000)) - 900000000;
                lon = int'($urandom_range(32'd3600000000) - 32'd1800000000);
            end
        endcase
        send_fix(lat[30:0], lon);
    endtask

    initial
    begin
        cycles = 0;
        results = 0;
        gaps_on = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        fix_latitude = '0;
        fix_longitude = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cur_lat = 0;
        cur_lon = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reference still disabled: no distance words
        for (int i = 0; i < 20; i++)
            random_fix();
        settle();

        set_reference(1'b1, 0, 0);
        send_fix(31'd0, 32'd0);
        send_fix(31'd900000000, 32'd0);
        send_fix(-31'sd900000000, 32'd0);
        send_fix(31'd0, 32'd1800000000);
        send_fix(31'd0, -32'sd1800000000);
        send_fix(31'h3FFFFFFF, 32'h7FFFFFFF);
        send_fix(31'h40000000, 32'h80000000);
        send_fix(31'h7FFFFFFF, 32'hFFFFFFFF);
        send_fix(31'd1, 32'd1);
        settle();
        set_reference(1'b1, 900000000, 1800000000);
        send_fix(-31'sd900000000, -32'sd1800000000);
        send_fix(31'd900000000, 32'd1800000000);
        send_fix(31'd0, 32'd0);
        send_fix(31'h40000000, 32'h80000000);
        settle();
        set_reference(1'b1, -900000000, -1800000000);
        send_fix(31'd900000000, 32'd1800000000);
        send_fix(31'h3FFFFFFF, 32'h7FFFFFFF);
        send_fix(31'd0, 32'd0);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: set_reference(1'b1, 31'h3FFFFFFF, 32'h7FFFFFFF);
                1: set_reference(1'b1, int'(31'sh40000000), int'(32'h80000000));
                2: set_reference(1'b0, 123456789, -98765432);
                default: set_reference(1'b1,
                    int'($urandom_range(1800000000)) - 900000000,
                    int'($urandom_range(32'd3600000000) - 32'd1800000000));
            endcase
            for (int i = 0; i < WORDS_PER_PHASE; i++)
            begin
                gaps_on = !(p == 4 && i >= 40 && i < 160);
                random_fix();
            end
            settle();
        end

        $display("covered %0d fix words, %0d distance words, %0d reference settings",
                 words_seen, results, PHASES + 3);
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
design/hvd_pkg.sv
design/hvd_rot_cell.sv
design/hvd_vec_cell.sv
design/hvd_sqrt_cell.sv
design/haversine_distance.sv
tb/hvd_checker.sv
tb/tb.sv
